// File: design/multi_axis_bresenham_step_generator_macros.svh
// Assertion macros shared by the checker of the step generator.
// No dependencies; included by the files that carry assertions.
`ifndef MULTI_AXIS_BRESENHAM_STEP_GENERATOR_MACROS_SVH
`define MULTI_AXIS_BRESENHAM_STEP_GENERATOR_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define MABSG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define MABSG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/mabsg_pkg.sv
// Shared types and constants of the multi-axis step generator.
// No dependencies; imported by every module of the block but the queue.
package mabsg_pkg;

    localparam int STEP_IN_W  = 31;
    localparam int POS_W      = 32;
    localparam int SEL_W      = 2;
    localparam int DIR_W      = 4;
    localparam int FIELD_AXES = 4;

    localparam int S_TDATA_W = 200;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 144;

    // Input beat layout
    localparam int S_STEPS_LSB = 0;
    localparam int S_EVENT_LSB = 124;
    localparam int S_DIRS_LSB  = 155;
    localparam int S_SEL_LSB   = 159;
    localparam int S_VALUE_LSB = 161;

    // Output beat layout
    localparam int M_STEPS_LSB = 0;
    localparam int M_DIRS_LSB  = 4;
    localparam int M_BUSY_BIT  = 8;
    localparam int M_POS_LSB   = 9;
    localparam int M_USED_W    = M_POS_LSB + FIELD_AXES * POS_W;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_TICK    = 2'd1,
        OP_SET_POS = 2'd2,
        OP_ABORT   = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [SEL_W-1:0] sel;
        logic             sel_ok;
        logic             ev_nonzero;
    } t_ctrl;

endpackage

// File: design/mabsg_front.sv
// Front end: unpacks an input beat, clamps axis counts and classifies it.
// Depends on mabsg_pkg.
module mabsg_front #(
    parameter int NUM_AXES   = 4,
    parameter int COUNT_BITS = 31,
    parameter int STEP_W     = 31
) (
    input  logic [mabsg_pkg::S_TDATA_W-1:0] i_tdata,
    input  logic [mabsg_pkg::S_TUSER_W-1:0] i_tuser,
    output mabsg_pkg::t_ctrl                o_ctrl,
    output logic [NUM_AXES-1:0]             o_dirs,
    output logic [STEP_W-1:0]               o_steps [NUM_AXES],
    output logic [COUNT_BITS-1:0]           o_event,
    output logic [mabsg_pkg::POS_W-1:0]     o_value
);
    import mabsg_pkg::*;

    logic [SEL_W-1:0] sel;

    assign sel      = i_tdata[S_SEL_LSB +: SEL_W];
    assign o_event  = COUNT_BITS'(i_tdata[S_EVENT_LSB +: STEP_W]);
    assign o_value  = i_tdata[S_VALUE_LSB +: POS_W];

    assign o_ctrl.op         = t_op'(i_tuser);
    assign o_ctrl.sel        = sel;
    assign o_ctrl.sel_ok     = (int'(sel) < NUM_AXES);
    assign o_ctrl.ev_nonzero = |o_event;

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        if (a < FIELD_AXES) begin : g_field
            logic [STEP_W-1:0] s_in;
            // An axis never steps more often than once per event.
            assign s_in       = i_tdata[S_STEPS_LSB + a * STEP_IN_W +: STEP_W];
            assign o_steps[a] = (COUNT_BITS'(s_in) > o_event) ? o_event[STEP_W-1:0] : s_in;
            assign o_dirs[a]  = i_tdata[S_DIRS_LSB + a];
        end else begin : g_extra
            assign o_steps[a] = '0;
            assign o_dirs[a]  = 1'b0;
        end
    end

endmodule

// File: design/mabsg_queue.sv
// Short register queue between the front and back ends.
// No package dependencies.
module mabsg_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// File: design/mabsg_back.sv
// Back end: move state, per-axis error accumulators and the result register.
// Depends on mabsg_pkg.
module mabsg_back #(
    parameter int NUM_AXES   = 4,
    parameter int COUNT_BITS = 31,
    parameter int STEP_W     = 31
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_pop,
    input  mabsg_pkg::t_ctrl                i_ctrl,
    input  logic [NUM_AXES-1:0]             i_dirs,
    input  logic [STEP_W-1:0]               i_steps [NUM_AXES],
    input  logic [COUNT_BITS-1:0]           i_event,
    input  logic [mabsg_pkg::POS_W-1:0]     i_value,
    input  logic [mabsg_pkg::DIR_W-1:0]     i_inv_mask,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [mabsg_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                            o_m_tlast
);
    import mabsg_pkg::*;

    localparam int AW = COUNT_BITS + 1;

    logic [AW-1:0]         r_accum [NUM_AXES], n_accum [NUM_AXES];
    logic [STEP_W-1:0]     r_steps [NUM_AXES], n_steps [NUM_AXES];
    logic [POS_W-1:0]      r_pos   [NUM_AXES], n_pos   [NUM_AXES];
    logic [COUNT_BITS-1:0] r_total, n_total;
    logic [COUNT_BITS-1:0] r_done_cnt, n_done_cnt;
    logic [NUM_AXES-1:0]   r_dir, n_dir;
    logic                  r_active, n_active;
    logic                  r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0]  r_out_data, n_out_data;
    logic                  r_out_last;

    logic [AW-1:0]         sum [NUM_AXES];
    logic [AW-1:0]         half_neg;
    logic [NUM_AXES-1:0]   step_vec;
    logic                  done_flag;

    logic [FIELD_AXES-1:0] out_steps;
    logic [FIELD_AXES-1:0] out_dirs;
    logic [POS_W-1:0]      out_pos [FIELD_AXES];

    assign o_pop    = i_valid && (!r_out_valid || i_m_tready);
    assign half_neg = '0 - {2'b00, i_event[COUNT_BITS-1:1]};

    always_comb begin
        n_accum    = r_accum;
        n_steps    = r_steps;
        n_pos      = r_pos;
        n_total    = r_total;
        n_done_cnt = r_done_cnt;
        n_dir      = r_dir;
        n_active   = r_active;
        step_vec   = '0;
        done_flag  = 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
            sum[a] = r_accum[a] + AW'(r_steps[a]);
        end
        case (i_ctrl.op)
            OP_LOAD: begin
                n_total    = i_event;
                n_done_cnt = '0;
                n_dir      = i_dirs;
                n_active   = i_ctrl.ev_nonzero;
                for (int a = 0; a < NUM_AXES; a++) begin
                    n_steps[a] = i_steps[a];
                    n_accum[a] = half_neg;
                end
            end
            OP_TICK: begin
                if (r_active) begin
                    for (int a = 0; a < NUM_AXES; a++) begin
                        n_accum[a] = sum[a];
                        if (!sum[a][AW-1] && (|sum[a])) begin
                            n_accum[a]  = sum[a] - AW'(r_total);
                            step_vec[a] = 1'b1;
                            n_pos[a]    = r_dir[a] ? r_pos[a] - POS_W'(1)
                                                   : r_pos[a] + POS_W'(1);
                        end
                    end
                    n_done_cnt = r_done_cnt + COUNT_BITS'(1);
                    if (n_done_cnt >= r_total) begin
                        n_active  = 1'b0;
                        done_flag = 1'b1;
                    end
                end
            end
            OP_SET_POS: begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (i_ctrl.sel_ok && (int'(i_ctrl.sel) == a)) begin
                        n_pos[a] = i_value;
                    end
                end
            end
            OP_ABORT: begin
                n_active = 1'b0;
            end
            default: begin
                n_active = r_active;
            end
        endcase
    end

    for (genvar b = 0; b < FIELD_AXES; b++) begin : g_out
        if (b < NUM_AXES) begin : g_used
            assign out_steps[b] = step_vec[b];
            assign out_dirs[b]  = ~n_dir[b] ^ i_inv_mask[b];
            assign out_pos[b]   = n_pos[b];
        end else begin : g_unused
            assign out_steps[b] = 1'b0;
            assign out_dirs[b]  = i_inv_mask[b];
            assign out_pos[b]   = '0;
        end
    end

    assign n_out_data = {{(M_TDATA_W - M_USED_W){1'b0}},
                         out_pos[3], out_pos[2], out_pos[1], out_pos[0],
                         n_active, out_dirs, out_steps};

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_pop) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_done_cnt  <= '0;
            r_dir       <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_accum[a] <= '0;
                r_steps[a] <= '0;
                r_pos[a]   <= '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_total    <= n_total;
                r_done_cnt <= n_done_cnt;
                r_dir      <= n_dir;
                r_active   <= n_active;
                r_accum    <= n_accum;
                r_steps    <= n_steps;
                r_pos      <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= n_out_data;
            r_out_last <= done_flag;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

// File: design/multi_axis_bresenham_step_generator.sv
// Top level of the multi-axis Bresenham step generator.
// Depends on mabsg_pkg, mabsg_front, mabsg_queue and mabsg_back.

// Every input beat produces exactly one result beat, in order. A load beat
// (tuser = load) starts a move: axis counts are clamped to the event count and
// each error accumulator starts at minus half the event count. Each tick beat
// of an active move adds every axis count to its accumulator; an axis whose
// accumulator turns positive steps once, moves its position by one and has the
// event count taken off again. The move finishes on its event-count tick, which
// the result marks with tlast. Set-position and abort beats act at once, also
// during a move. The block sustains one beat per clock while the queue has room:
// the front end decodes and clamps a beat in the cycle it is accepted, a
// two-entry queue holds it, and the back end carries it out once the result
// register is free or being taken, with one add, compare and subtract per
// axis, writing the result register. The input side only stalls once the
// result register is held and the queue is full.
// The direction mask register may be written only while no beat is in flight.
module multi_axis_bresenham_step_generator #(
    parameter int NUM_AXES   = 4,
    parameter int COUNT_BITS = 31
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // steps_x, steps_y, steps_z, steps_e, event_count, move_dirs, axis_sel,
    // position_value, zero fill
    input  logic [mabsg_pkg::S_TDATA_W-1:0] i_s_tdata,
    // operation
    input  logic [mabsg_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // step_bits, dir_levels, busy_res, pos_x, pos_y, pos_z, pos_e, zero fill
    output logic [mabsg_pkg::M_TDATA_W-1:0] o_m_tdata,
    // move_done
    output logic                            o_m_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    input  logic                            i_cfg_wr_en,
    input  logic [mabsg_pkg::DIR_W-1:0]     i_cfg_wr_data
);
    import mabsg_pkg::*;

    // Clamped counts never exceed the narrower of the port and the counter.
    localparam int SW       = (COUNT_BITS < STEP_IN_W) ? COUNT_BITS : STEP_IN_W;
    localparam int CTRL_W   = $bits(t_ctrl);
    localparam int VAL_LSB  = 0;
    localparam int EV_LSB   = VAL_LSB + POS_W;
    localparam int STP_LSB  = EV_LSB + COUNT_BITS;
    localparam int DIR_LSB  = STP_LSB + NUM_AXES * SW;
    localparam int CTRL_LSB = DIR_LSB + NUM_AXES;
    localparam int QW       = CTRL_LSB + CTRL_W;

    logic [DIR_W-1:0]      r_inv_mask;

    t_ctrl                 f_ctrl, b_ctrl;
    logic [NUM_AXES-1:0]   f_dirs, b_dirs;
    logic [SW-1:0]         f_steps [NUM_AXES];
    logic [SW-1:0]         b_steps [NUM_AXES];
    logic [COUNT_BITS-1:0] f_event, b_event;
    logic [POS_W-1:0]      f_value, b_value;

    logic [QW-1:0]         q_in, q_out;
    logic                  q_full, q_valid, q_push, q_pop;

    // The direction inversion mask is the only software register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_mask <= '0;
        end else if (i_cfg_wr_en) begin
            r_inv_mask <= i_cfg_wr_data;
        end
    end

    mabsg_front #(
        .NUM_AXES   (NUM_AXES),
        .COUNT_BITS (COUNT_BITS),
        .STEP_W     (SW)
    ) u_front (
        .i_tdata (i_s_tdata),
        .i_tuser (i_s_tuser),
        .o_ctrl  (f_ctrl),
        .o_dirs  (f_dirs),
        .o_steps (f_steps),
        .o_event (f_event),
        .o_value (f_value)
    );

    // A beat is taken whenever the queue has room, independent of the back end.
    assign o_s_tready = !q_full;
    assign q_push     = i_s_tvalid && !q_full;

    assign q_in[VAL_LSB +: POS_W]       = f_value;
    assign q_in[EV_LSB +: COUNT_BITS]   = f_event;
    assign q_in[DIR_LSB +: NUM_AXES]    = f_dirs;
    assign q_in[CTRL_LSB +: CTRL_W]     = f_ctrl;
    assign b_value                      = q_out[VAL_LSB +: POS_W];
    assign b_event                      = q_out[EV_LSB +: COUNT_BITS];
    assign b_dirs                       = q_out[DIR_LSB +: NUM_AXES];
    assign b_ctrl                       = t_ctrl'(q_out[CTRL_LSB +: CTRL_W]);

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_pack
        assign q_in[STP_LSB + a * SW +: SW] = f_steps[a];
        assign b_steps[a]                   = q_out[STP_LSB + a * SW +: SW];
    end

    mabsg_queue #(
        .W     (QW),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    mabsg_back #(
        .NUM_AXES   (NUM_AXES),
        .COUNT_BITS (COUNT_BITS),
        .STEP_W     (SW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .o_pop      (q_pop),
        .i_ctrl     (b_ctrl),
        .i_dirs     (b_dirs),
        .i_steps    (b_steps),
        .i_event    (b_event),
        .i_value    (b_value),
        .i_inv_mask (r_inv_mask),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// File: design/mabsg_checker.sv
// Port-level checker of the step generator, bound to the top level.
// Depends on mabsg_pkg and the shared assertion macro header.
`include "multi_axis_bresenham_step_generator_macros.svh"

module mabsg_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [mabsg_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic                            o_m_tlast,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready
);
    import mabsg_pkg::*;

    // Reset leaves an empty pipeline that is ready for the first beat.
    `MABSG_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (o_s_tready && !o_m_tvalid), "pipeline not empty after reset")

    // The finishing tick of a move always reports the block as idle.
    `MABSG_ASSERT(a_done_idle, i_clk, i_rst_n, (o_m_tvalid && o_m_tlast) |-> !o_m_tdata[M_BUSY_BIT], "move done while still busy")

    // An accepted beat has a result pending once it has passed the queue into the result register.
    `MABSG_ASSERT(a_result_latency, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) |-> ##2 o_m_tvalid, "no result after accepted beat")

    // A stalled result holds still.
    `MABSG_ASSERT(a_hold_stalled, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)), "stalled result changed")

endmodule

bind multi_axis_bresenham_step_generator mabsg_checker u_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multi-axis Bresenham step generator.
// Depends on mabsg_pkg and multi_axis_bresenham_step_generator; needs nothing else.

module testbench;
    import mabsg_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1350;
    localparam int SETTLE       = 4;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_PRINTED  = 40;

    // Input beat fields; the last member sits in the lowest bits, as on tdata.
    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         sel;
        logic [3:0]         dirs;
        logic [30:0]        events;
        logic [3:0][30:0]   steps;
    } move_fields_t;

    // Result beat fields as they sit on tdata.
    typedef struct packed {
        logic [3:0][31:0] pos;
        logic             busy;
        logic [3:0]       dirs;
        logic [3:0]       steps;
    } motion_word_t;

    typedef struct {
        motion_word_t word;
        logic         done;
    } motion_t;

    // Tracks the motion state of the block and holds the results still owed.
    class motion_scoreboard;
        logic signed [32:0] accum [4];
        logic [30:0]        axis_cnt [4];
        logic [30:0]        total_events;
        logic [30:0]        ticks_done;
        logic [3:0]         dir_bits;
        logic               move_active;
        logic [31:0]        position [4];
        logic [3:0]         invert_mask;
        motion_t            expected_q [$];
        int                 errors;

        function new();
            for (int a = 0; a < 4; a++) begin
                accum[a]    = '0;
                axis_cnt[a] = '0;
                position[a] = '0;
            end
            total_events = '0;
            ticks_done   = '0;
            dir_bits     = '0;
            move_active  = 1'b0;
            invert_mask  = '0;
            errors       = 0;
        endfunction

        function void note_beat(t_op op, move_fields_t f);
            motion_t m;
            m.done       = 1'b0;
            m.word.steps = '0;
            case (op)
                OP_LOAD: begin
                    total_events = f.events;
                    ticks_done   = '0;
                    dir_bits     = f.dirs;
                    for (int a = 0; a < 4; a++) begin
                        // Counts above the event count are clamped to it.
                        axis_cnt[a] = (f.steps[a] > f.events) ? f.events : f.steps[a];
                        accum[a]    = -$signed({2'b00, f.events >> 1});
                    end
                    move_active = (f.events != '0);
                end
                OP_TICK: begin
                    if (move_active) begin
                        for (int a = 0; a < 4; a++) begin
                            accum[a] = accum[a] + $signed({2'b00, axis_cnt[a]});
                            if (accum[a] > 0) begin
                                accum[a]        = accum[a] - $signed({2'b00, total_events});
                                m.word.steps[a] = 1'b1;
                                position[a]     = dir_bits[a] ? position[a] - 1
                                                              : position[a] + 1;
                            end
                        end
                        ticks_done = ticks_done + 1;
                        if (ticks_done >= total_events) begin
                            move_active = 1'b0;
                            m.done      = 1'b1;
                        end
                    end
                end
                OP_SET_POS: position[f.sel] = f.value;
                OP_ABORT:   move_active = 1'b0;
                default:    ;
            endcase
            m.word.dirs = ~dir_bits ^ invert_mask;
            m.word.busy = move_active;
            for (int a = 0; a < 4; a++)
                m.word.pos[a] = position[a];
            expected_q.push_back(m);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("%0t ns: %s differs, got %h, want %h", $time, what, got, want);
        endtask

        task check_beat(motion_word_t w, logic done);
            motion_t e;
            if (expected_q.size() == 0) begin
                report("result beat with none owed", 32'(w.steps), 32'd0);
                return;
            end
            e = expected_q.pop_front();
            if (w.steps !== e.word.steps)
                report("step_bits", 32'(w.steps), 32'(e.word.steps));
            if (w.dirs !== e.word.dirs)
                report("dir_levels", 32'(w.dirs), 32'(e.word.dirs));
            if (done !== e.done)
                report("move_done", 32'(done), 32'(e.done));
            if (w.busy !== e.word.busy)
                report("busy_res", 32'(w.busy), 32'(e.word.busy));
            for (int a = 0; a < 4; a++)
                if (w.pos[a] !== e.word.pos[a])
                    report($sformatf("position of axis %0d", a), w.pos[a], e.word.pos[a]);
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic [S_TDATA_W-1:0]  i_s_tdata     = '0;
    logic [S_TUSER_W-1:0]  i_s_tuser     = '0;
    logic                  i_s_tvalid    = 1'b0;
    logic                  o_s_tready;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  o_m_tlast;
    logic                  o_m_tvalid;
    logic                  i_m_tready    = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [DIR_W-1:0]      i_cfg_wr_data = '0;

    motion_scoreboard board = new();
    int idle_pct    = 0;
    int stall_pct   = 0;
    int items_sent  = 0;
    int cycle_count = 0;

    multi_axis_bresenham_step_generator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: check each accepted beat, then decide whether to stall next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_beat(motion_word_t'(o_m_tdata[M_USED_W-1:0]), o_m_tlast);
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_beat(t_op op, move_fields_t f);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_TDATA_W'(f);
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        // Ticks and aborts with no move running change nothing, so they are not counted.
        if (!((op == OP_TICK || op == OP_ABORT) && !board.move_active))
            items_sent++;
        board.note_beat(op, f);
    endtask

    // Waits until every owed result has arrived, then writes the direction mask.
    task automatic write_mask(logic [3:0] mask_val);
        i_s_tvalid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mask_val;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        board.invert_mask = mask_val;
    endtask

    function automatic move_fields_t noise_fields();
        move_fields_t f;
        for (int a = 0; a < 4; a++)
            f.steps[a] = 31'($urandom);
        f.events = 31'($urandom);
        f.dirs   = 4'($urandom);
        f.sel    = 2'($urandom);
        f.value  = $urandom;
        return f;
    endfunction

    function automatic logic [30:0] axis_count(logic [30:0] ev);
        case ($urandom_range(5))
            0:       return '0;
            1:       return ev;
            2:       return 31'($urandom);
            default: return 31'($urandom_range(ev, 0));
        endcase
    endfunction

    task automatic load_move(logic [30:0] ev, logic [3:0][30:0] counts, logic [3:0] dirs);
        move_fields_t f;
        f        = noise_fields();
        f.events = ev;
        f.steps  = counts;
        f.dirs   = dirs;
        send_beat(OP_LOAD, f);
    endtask

    task automatic set_axis(logic [1:0] sel, logic [31:0] value);
        move_fields_t f;
        f       = noise_fields();
        f.sel   = sel;
        f.value = value;
        send_beat(OP_SET_POS, f);
    endtask

    task automatic tick_n(int n);
        repeat (n) send_beat(OP_TICK, noise_fields());
    endtask

    // Counts in the load calls below are listed e, z, y, x.
    task automatic run_directed();
        tick_n(1);
        send_beat(OP_ABORT, noise_fields());
        set_axis(2'd0, 32'h7FFF_FFFF);
        set_axis(2'd1, 32'h8000_0000);
        set_axis(2'd2, 32'h0000_0000);
        set_axis(2'd3, 32'hFFFF_FFFF);
        // A zero event count leaves the move idle despite the full axis counts.
        load_move(31'd0, {4{31'h7FFF_FFFF}}, 4'h0);
        tick_n(1);
        // x and y run over the signed limits, y moving negative.
        load_move(31'd3, {31'd0, 31'd1, 31'd3, 31'd3}, 4'b0010);
        tick_n(4);
        // x asks for more steps than events and is clamped; z steps on every tick
        // and has its position set in the middle of the move.
        load_move(31'd4, {31'd1, 31'd4, 31'd2, 31'h7FFF_FFFF}, 4'hF);
        tick_n(1);
        set_axis(2'd2, 32'd100);
        tick_n(1);
        // A new load replaces the running move, which is later aborted.
        load_move(31'd2, {31'd2, 31'd0, 31'd2, 31'd1}, 4'b0101);
        tick_n(1);
        send_beat(OP_ABORT, noise_fields());
        tick_n(1);
        load_move(31'h7FFF_FFFF, {4{31'h7FFF_FFFF}}, 4'h0);
        tick_n(2);
        send_beat(OP_ABORT, noise_fields());
        load_move(31'd1, {4{31'd1}}, 4'hA);
        tick_n(1);
    endtask

    // A load with random content followed mostly by its full run of ticks,
    // with the odd set, abort or stray load thrown in.
    task automatic run_random_move();
        move_fields_t f;
        logic [30:0]  ev;
        int           n_ticks;
        if ($urandom_range(19) == 0)
            ev = 31'($urandom);
        else
            ev = 31'($urandom_range(1, 24));
        f        = noise_fields();
        f.events = ev;
        for (int a = 0; a < 4; a++)
            f.steps[a] = axis_count(ev);
        send_beat(OP_LOAD, f);
        n_ticks = (ev <= 24) ? int'(ev) : $urandom_range(1, 8);
        if ($urandom_range(9) == 0)
            n_ticks = $urandom_range(n_ticks, 0);
        else if ($urandom_range(4) == 0)
            n_ticks++;
        for (int t = 0; t < n_ticks; t++) begin
            case ($urandom_range(24))
                0:       send_beat(OP_SET_POS, noise_fields());
                1:       send_beat(OP_ABORT, noise_fields());
                2:       send_beat(OP_LOAD, noise_fields());
                default: ;
            endcase
            tick_n(1);
        end
    endtask

    task automatic run_random_part(int budget);
        int target;
        target = items_sent + budget;
        while (items_sent < target) begin
            if ($urandom_range(99) < 70)
                run_random_move();
            else
                send_beat(t_op'($urandom_range(3)), noise_fields());
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full rate on both sides.
        write_mask(4'hF);
        run_directed();
        run_random_part(RANDOM_ITEMS / 4);

        // Sparse input beats.
        idle_pct  = 86;
        stall_pct = 0;
        write_mask(4'h0);
        run_random_part(RANDOM_ITEMS / 4);

        // Heavy back-pressure on the result side.
        idle_pct  = 0;
        stall_pct = 86;
        write_mask(4'h5);
        run_random_part(RANDOM_ITEMS / 4);

        // Light gaps on both sides.
        idle_pct  = 12;
        stall_pct = 12;
        write_mask(4'($urandom));
        run_random_part(RANDOM_ITEMS / 4);

        i_s_tvalid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
